// ----- src/ise_pkg.sv -----
`default_nettype none
package ise_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 16;
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         end_of_set;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         run_last;
      logic                         overflow;
   } rsp_type;

   // what one cell hands to its upper neighbour
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         shift;
   } link_type;

   typedef struct packed {
      logic insert;
      logic drain;
      logic occupied;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage
`default_nettype wire

// ----- src/insertion_sort_engine_unit.sv -----
// Insertion sort engine: stable ascending sort of one data set.
// Request channel: drive req_data and raise start; a request is taken at a
// rising edge with start high and busy low. Each request inserts one value
// into a row of DEPTH compare-and-shift cells, all cells updating together,
// so while a set is being loaded one request can be taken every cycle.
// A request with end_of_set high is inserted and then the set is emitted:
// from the next cycle on, busy is high and one result a cycle appears on
// rsp_data with rsp_strobe high, smallest first, the row shifting down one
// cell per cycle. A set of n values yields min(n, DEPTH) results; the last
// result carries run_last and busy is low again in the cycle after it.
// Values beyond DEPTH in one set are dropped and every result of that run
// carries overflow.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// Reset (synchronous, active high) empties the row and clears the overflow
// flag; stored values need no reset since only filled cells are read.
`default_nettype none
module insertion_sort_engine_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire ise_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_strobe,
   output ise_pkg::rsp_type      rsp_data
);

   ise_pkg::state_type                 state_ff, state_in;
   logic [ise_pkg::CNT_WIDTH-1:0]      fill_ff, fill_in;
   logic                               dropped_ff, dropped_in;
   logic                               accept;
   logic                               has_room;
   logic                               do_insert;
   ise_pkg::link_type                  links [ise_pkg::DEPTH];

   assign busy      = (state_ff == ise_pkg::ST_DRAIN);
   assign accept    = start && !busy;
   assign has_room  = (fill_ff < ise_pkg::CNT_WIDTH'(ise_pkg::DEPTH));
   assign do_insert = accept && has_room;

   genvar g;
   generate
      for (g = 0; g < ise_pkg::DEPTH; g++) begin : g_cell
         ise_pkg::cell_ctl_type                 ctl;
         ise_pkg::link_type                     lower;
         logic signed [ise_pkg::DATA_WIDTH-1:0] upper;

         assign ctl.insert   = do_insert;
         assign ctl.drain    = busy;
         assign ctl.occupied = (ise_pkg::CNT_WIDTH'(g) < fill_ff);

         if (g == 0) begin : g_first
            assign lower.value = req_data.value;
            assign lower.shift = 1'b0;
         end else begin : g_inner
            assign lower = links[g-1];
         end

         if (g == ise_pkg::DEPTH - 1) begin : g_last
            assign upper = '0;
         end else begin : g_mid
            assign upper = links[g+1].value;
         end

         ise_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .new_value   (req_data.value),
            .lower_link  (lower),
            .upper_value (upper),
            .link_out    (links[g])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ise_pkg::ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  fill_in = fill_ff + ise_pkg::CNT_WIDTH'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.end_of_set) begin
                  state_in = ise_pkg::ST_DRAIN;
               end
            end
         end
         ise_pkg::ST_DRAIN: begin
            fill_in = fill_ff - ise_pkg::CNT_WIDTH'(1);
            if (fill_ff == ise_pkg::CNT_WIDTH'(1)) begin
               state_in   = ise_pkg::ST_IDLE;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ise_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ise_pkg::ST_IDLE;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_strobe            = busy;
   assign rsp_data.sorted_value = links[0].value;
   assign rsp_data.run_last     = (fill_ff == ise_pkg::CNT_WIDTH'(1));
   assign rsp_data.overflow     = dropped_ff;

endmodule
`default_nettype wire

// ----- src/ise_cell.sv -----
`default_nettype none
module ise_cell (
   input  wire logic                                  clock,
   input  wire ise_pkg::cell_ctl_type                 ctl,
   input  wire logic signed [ise_pkg::DATA_WIDTH-1:0] new_value,
   input  wire ise_pkg::link_type                     lower_link,
   input  wire logic signed [ise_pkg::DATA_WIDTH-1:0] upper_value,
   output ise_pkg::link_type                          link_out
);

   logic signed [ise_pkg::DATA_WIDTH-1:0] value_ff;
   logic signed [ise_pkg::DATA_WIDTH-1:0] value_in;
   logic                                  shift;

   // strictly greater moves up, so equal keys keep arrival order
   assign shift = !ctl.occupied || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      if (ctl.drain) begin
         value_in = upper_value;
      end else if (ctl.insert && shift) begin
         value_in = lower_link.shift ? lower_link.value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link_out.value = value_ff;
   assign link_out.shift = shift;

endmodule
`default_nettype wire

// ----- tb/sv/ise_sort_checker.sv -----
`timescale 1ns / 1ps
module ise_sort_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ise_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  ise_pkg::rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int               pending_results
);

   logic signed [ise_pkg::DATA_WIDTH-1:0] sorted_image [ise_pkg::DEPTH];
   int                                    fill_level;
   logic                                  dropped;
   ise_pkg::rsp_type                      expected_sorted_q [$];

   // stable: only strictly greater entries move up
   task automatic insert_value(input logic signed [ise_pkg::DATA_WIDTH-1:0] v);
      int pos;
      if (fill_level >= ise_pkg::DEPTH) begin
         dropped = 1'b1;
      end else begin
         pos = fill_level;
         while (pos > 0 && sorted_image[pos-1] > v) begin
            sorted_image[pos] = sorted_image[pos-1];
            pos--;
         end
         sorted_image[pos] = v;
         fill_level++;
      end
   endtask

   task automatic queue_sorted_run();
      ise_pkg::rsp_type r;
      for (int k = 0; k < fill_level; k++) begin
         r.sorted_value = sorted_image[k];
         r.run_last     = (k == fill_level - 1);
         r.overflow     = dropped;
         expected_sorted_q.push_back(r);
      end
      fill_level = 0;
      dropped    = 1'b0;
   endtask

   always @(posedge clock) begin
      ise_pkg::rsp_type want;
      if (reset) begin
         fill_level = 0;
         dropped    = 1'b0;
         expected_sorted_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_sorted_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: value %0d last %b ovf %b",
                           rsp_data.sorted_value, rsp_data.run_last, rsp_data.overflow);
            end else begin
               want = expected_sorted_q.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value ||
                   rsp_data.run_last !== want.run_last ||
                   rsp_data.overflow !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: exp value %0d last %b ovf %b, ",
                               "got value %0d last %b ovf %b"},
                              want.sorted_value, want.run_last, want.overflow,
                              rsp_data.sorted_value, rsp_data.run_last, rsp_data.overflow);
               end
            end
         end
         if (start && !busy) begin
            insert_value(req_data.value);
            if (req_data.end_of_set)
               queue_sorted_run();
         end
      end
      pending_results = expected_sorted_q.size();
   end

endmodule

// ----- tb/sv/insertion_sort_engine_unit_tb.sv -----
`timescale 1ns / 1ps
module insertion_sort_engine_unit_tb;

   localparam int RANDOM_ITEMS = 255;
   localparam int QUIET_TAIL   = 30;
   localparam int LIMIT_CYCLES = 100000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   ise_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   ise_pkg::rsp_type rsp_data;
   int unsigned      mismatch_count;
   int               pending_results;
   int               cycle_count = 0;
   int               items_sent = 0;
   bit               idle_enabled = 1'b1;

   insertion_sort_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   ise_sort_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [ise_pkg::DATA_WIDTH-1:0] v, input logic eos);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= '{value: v, end_of_set: eos};
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic logic [ise_pkg::DATA_WIDTH-1:0] pick_value(input int mode);
      logic [ise_pkg::DATA_WIDTH-1:0] extremes [5];
      extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
      case (mode)
         0:       return ise_pkg::DATA_WIDTH'($urandom_range(0, 65535));
         1:       return ise_pkg::DATA_WIDTH'($urandom_range(0, 8) - 4);
         default: return extremes[$urandom_range(0, 4)];
      endcase
   endfunction

   task automatic send_set(input int len);
      int mode;
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
         send_request(pick_value(mode > 2 ? 0 : mode), i == len - 1);
   endtask

   initial begin
      int len;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, duplicate of the most negative value
      send_request(16'h7fff, 1'b0);
      send_request(16'h8000, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'hffff, 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'h8000, 1'b1);
      // set of one
      send_request(16'h0005, 1'b1);
      // overflow: one dropped mid-set, then the last request hits a full store
      for (int i = 0; i < 17; i++)
         send_request(ise_pkg::DATA_WIDTH'((i % 5) - 2), 1'b0);
      send_request(16'h0003, 1'b1);

      // hold off until the backlog has drained
      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);

      while (items_sent < 25 + RANDOM_ITEMS) begin
         if (items_sent > 25 + RANDOM_ITEMS - QUIET_TAIL)
            idle_enabled = 1'b0;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
         send_set(len);
      end

      start <= 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/ise_pkg.sv
src/ise_cell.sv
src/insertion_sort_engine_unit.sv
tb/sv/ise_sort_checker.sv
tb/sv/insertion_sort_engine_unit_tb.sv
